// ===== rtl/assert_macros.svh =====
// Shared assertion macros for the hasher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/sha_pkg.sv =====
`default_nettype none

package sha_pkg;

    typedef logic [31:0] t_word;

    localparam int unsigned NumRounds = 64;
    localparam int unsigned NumHash   = 8;

    // Round constants.
    function automatic t_word k_const(input logic [5:0] idx);
        t_word k;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Initial chaining values.
    function automatic t_word iv_const(input logic [2:0] idx);
        t_word h;
        case (idx)
            3'd0: h = 32'h6a09e667;
            3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372;
            3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f;
            3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            3'd7: h = 32'h5be0cd19;
            default: h = 32'h0;
        endcase
        return h;
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sha256_stream_hasher.sv =====
// Byte beat: taken while buffering; a filled 64-byte block then stalls input for
// a chaining read, 64 rounds at one per cycle and a chaining write-back.
// End mark: padding bytes (1..64 per block) are shifted in, one or two block compressions,
// then 8 digest beats, each read, presented and accepted (i_out_stall holds the accept).
// A pass through ST_INIT then rewrites the initial values before the next beat.
// Reset (synchronous, active low) runs that same initialization pass.
`default_nettype none
`include "assert_macros.svh"

module sha256_stream_hasher import sha_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_has_byte,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_message,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word
);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_PAD   = 3'd2;
    localparam logic [2:0] ST_LOAD  = 3'd3;
    localparam logic [2:0] ST_ROUND = 3'd4;
    localparam logic [2:0] ST_ADD   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    // Control state
    logic [2:0]  r_state;
    logic [3:0]  r_cnt;
    logic [5:0]  r_round;
    logic [5:0]  r_count;
    logic [63:0] r_len;
    logic        r_pad;
    logic        r_marked;
    logic        r_len_blk;
    logic        r_final;
    logic [2:0]  r_oidx;
    logic        r_rd_ok;
    logic        r_ovalid;

    // Datapath state
    logic [511:0] r_buf;
    t_word        r_v [NumHash];
    t_word        r_chain_mem [NumHash];
    t_word        r_rdata;
    t_word        r_dword;
    logic         r_last;

    logic         in_acc;
    logic         out_acc;
    logic [7:0]   pad_byte;
    t_word        sched_w;
    t_word        round_wi;
    t_word        round_t1;
    t_word        round_t2;
    logic [2:0]   rd_addr;
    logic         wr_en;
    logic [2:0]   wr_addr;
    t_word        wr_data;

    assign in_acc  = i_in_valid && (r_state == ST_IDLE);
    assign out_acc = r_ovalid && !i_out_stall;

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_ovalid;
    assign o_digest_word = r_dword;
    assign o_word_index  = r_oidx;
    assign o_last_word   = r_last;

    // Padding byte: marker, zeros, then big-endian bit count in the last eight slots
    always_comb begin
        if (!r_marked) begin
            pad_byte = 8'h80;
        end else if (r_len_blk && (r_count[5:3] == 3'b111)) begin
            pad_byte = r_len[{~r_count[2:0], 3'b000} +: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    // Schedule word and round sums
    assign sched_w  = r_buf[511:480] + small_sigma0(r_buf[479:448])
                    + r_buf[223:192] + small_sigma1(r_buf[63:32]);
    assign round_wi = (r_round < 6'd16) ? r_buf[511:480] : sched_w;
    assign round_t1 = r_v[7] + big_sigma1(r_v[4])
                    + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
                    + k_const(r_round) + round_wi;
    assign round_t2 = big_sigma0(r_v[0])
                    + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    // Chaining memory port steering
    always_comb begin
        rd_addr = r_oidx;
        wr_en   = 1'b0;
        wr_addr = r_cnt[2:0];
        wr_data = iv_const(r_cnt[2:0]);
        case (r_state)
            ST_INIT: begin
                wr_en = 1'b1;
            end
            ST_LOAD: begin
                rd_addr = r_cnt[2:0];
            end
            ST_ADD: begin
                rd_addr = r_cnt[2:0];
                wr_en   = (r_cnt != 4'd0);
                wr_addr = 3'(r_cnt - 4'd1);
                wr_data = r_rdata + r_v[0];
            end
            default: begin
                rd_addr = r_oidx;
            end
        endcase
    end

    // Chaining memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_chain_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_chain_mem[rd_addr];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_cnt     <= '0;
            r_round   <= '0;
            r_count   <= '0;
            r_len     <= '0;
            r_pad     <= 1'b0;
            r_marked  <= 1'b0;
            r_len_blk <= 1'b0;
            r_final   <= 1'b0;
            r_oidx    <= '0;
            r_rd_ok   <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            case (r_state)
                ST_INIT: begin
                    r_count   <= '0;
                    r_len     <= '0;
                    r_pad     <= 1'b0;
                    r_marked  <= 1'b0;
                    r_len_blk <= 1'b0;
                    r_final   <= 1'b0;
                    r_cnt     <= r_cnt + 4'd1;
                    if (r_cnt == 4'd7) begin
                        r_cnt   <= '0;
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_acc) begin
                        if (i_has_byte) begin
                            r_count <= r_count + 6'd1;
                            r_len   <= r_len + 64'd8;
                        end
                        if (i_has_byte && (r_count == 6'd63)) begin
                            r_pad   <= i_end_of_message;
                            r_cnt   <= '0;
                            r_state <= ST_LOAD;
                        end else if (i_end_of_message) begin
                            r_pad   <= 1'b1;
                            r_state <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    r_count <= r_count + 6'd1;
                    if (!r_marked) begin
                        r_marked  <= 1'b1;
                        r_len_blk <= (r_count <= 6'd55);
                    end
                    // block full: compress, final if the length went in
                    if (r_count == 6'd63) begin
                        r_final   <= r_marked && r_len_blk;
                        r_len_blk <= 1'b1;
                        r_cnt     <= '0;
                        r_state   <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd8) begin
                        r_cnt   <= '0;
                        r_round <= '0;
                        r_state <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'(NumRounds - 1)) begin
                        r_cnt   <= '0;
                        r_state <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd8) begin
                        r_cnt <= '0;
                        if (r_final) begin
                            r_oidx  <= '0;
                            r_rd_ok <= 1'b0;
                            r_state <= ST_OUT;
                        end else if (r_pad) begin
                            r_state <= ST_PAD;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_OUT: begin
                    if (out_acc) begin
                        r_ovalid <= 1'b0;
                        r_rd_ok  <= 1'b0;
                        r_oidx   <= r_oidx + 3'd1;
                        if (r_last) begin
                            r_cnt   <= '0;
                            r_state <= ST_INIT;
                        end
                    end else if (!r_ovalid) begin
                        if (r_rd_ok) begin
                            r_ovalid <= 1'b1;
                        end else begin
                            r_rd_ok <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_INIT;
                end
            endcase
        end
    end

    // Block buffer, working variables and output payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_has_byte) begin
                    r_buf <= {r_buf[503:0], i_data_byte};
                end
            end
            ST_PAD: begin
                r_buf <= {r_buf[503:0], pad_byte};
            end
            ST_LOAD: begin
                // shift chaining words in, entry 0 ends up in slot 0
                if (r_cnt != 4'd0) begin
                    for (int i = 0; i < NumHash - 1; i++) begin
                        r_v[i] <= r_v[i + 1];
                    end
                    r_v[NumHash - 1] <= r_rdata;
                end
            end
            ST_ROUND: begin
                r_buf  <= {r_buf[479:0], round_wi};
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + round_t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= round_t1 + round_t2;
            end
            ST_ADD: begin
                // rotate so the next word to add sits in slot 0
                if (r_cnt != 4'd0) begin
                    for (int i = 0; i < NumHash - 1; i++) begin
                        r_v[i] <= r_v[i + 1];
                    end
                    r_v[NumHash - 1] <= r_v[0];
                end
            end
            ST_OUT: begin
                if (!r_ovalid && r_rd_ok) begin
                    r_dword <= r_rdata;
                    r_last  <= (r_oidx == 3'd7);
                end
            end
            default: begin
                r_last <= r_last;
            end
        endcase
    end

    `ASSERT_IMPLIES(a_out_only_in_out, i_clk, i_rst_n, r_ovalid, r_state == ST_OUT)
    `ASSERT_IMPLIES(a_write_in_init_add, i_clk, i_rst_n, wr_en, (r_state == ST_INIT) || (r_state == ST_ADD))
    `ASSERT_NEXT(a_last_then_init, i_clk, i_rst_n, out_acc && r_last, r_state == ST_INIT)
    `ASSERT_IMPLIES(a_final_after_mark, i_clk, i_rst_n, r_final, r_marked && r_pad)

endmodule

`default_nettype wire
